// File: hw/rtl/cld_pkg.sv
`default_nettype none

package cld_pkg;

	// Slot geometry; a slot pointer carries one extra code for null.
	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SLOT_W  = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int CNT_W   = 11;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;

	localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(DEPTH);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(1024);

	// Request codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed_value;
		logic [STAT_W-1:0]         status;
		logic [CNT_W-1:0]          count;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
	} result_t;

	// One memory access per cycle: an optional write and a read
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [VALUE_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr;
	} val_acc_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [SLOT_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} link_acc_t;

endpackage

`default_nettype wire

// File: hw/rtl/cld_store.sv
`default_nettype none

module cld_store import cld_pkg::*; (
	input  wire logic               clk,
	input  wire val_acc_t           val_acc,
	input  wire link_acc_t          next_acc,
	input  wire link_acc_t          prev_acc,
	output logic [VALUE_W-1:0]      val_rd,
	output logic [SLOT_W-1:0]       next_rd,
	output logic [SLOT_W-1:0]       prev_rd
);

	// Slot values and the two link arrays, each one write and one registered read
	logic [VALUE_W-1:0] val_mem  [DEPTH];
	logic [SLOT_W-1:0]  next_mem [DEPTH];
	logic [SLOT_W-1:0]  prev_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (val_acc.we) begin
			val_mem[val_acc.waddr] <= val_acc.wdata;
		end
		val_rd <= val_mem[val_acc.raddr];
	end

	always_ff @(posedge clk) begin
		if (next_acc.we) begin
			next_mem[next_acc.waddr] <= next_acc.wdata;
		end
		next_rd <= next_mem[next_acc.raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_acc.we) begin
			prev_mem[prev_acc.waddr] <= prev_acc.wdata;
		end
		prev_rd <= prev_mem[prev_acc.raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/cursor_linked_deque.sv
// Channel     Direction  Signals                         Transaction
// ----------  ---------  ------------------------------  -------------------------------
// command     in         start, busy, cmd (cmd_t)        start high while busy low
// result      out        done, result (result_t)         done high for one cycle
// config      in         cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// Steps: an insert, a refused request or an unused code passes through accept and
// link update (S_IDLE, S_LINK); a removal adds a value fetch of the new end
// (S_FIN). The extra step is the registered read of the value memory at the slot
// that the link memory just returned. done rises the cycle after the last step,
// and busy is already low then, so the next command can be accepted alongside it.
// Reset empties the list and the free list and returns every slot to the never-used region.
// The receiver cannot stall; the result register holds each result until the next one.
`default_nettype none

module cursor_linked_deque import cld_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cmd_t             cmd,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LINK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	// Control state
	logic [1:0]        state_q, state_nxt;
	logic [SLOT_W-1:0] head_q, head_nxt;
	logic [SLOT_W-1:0] tail_q, tail_nxt;
	logic [SLOT_W-1:0] free_q, free_nxt;
	logic [SLOT_W-1:0] mark_q, mark_nxt;
	logic [CNT_W-1:0]  count_q, count_nxt;
	logic [CNT_W-1:0]  cap_q;
	logic              done_q, done_nxt;

	// Command held through its steps, cached end values, result register
	logic [FUNC_W-1:0]  func_q;
	logic [VALUE_W-1:0] value_q;
	logic [STAT_W-1:0]  status_q;
	logic [VALUE_W-1:0] front_q, front_nxt;
	logic [VALUE_W-1:0] back_q, back_nxt;
	result_t            result_q, result_nxt;

	// Memory side
	val_acc_t           val_acc;
	link_acc_t          next_acc;
	link_acc_t          prev_acc;
	logic [VALUE_W-1:0] val_rd;
	logic [SLOT_W-1:0]  next_rd;
	logic [SLOT_W-1:0]  prev_rd;

	logic              accept;
	logic [CNT_W-1:0]  cap_eff;
	logic [STAT_W-1:0] acc_status;
	logic [SLOT_W-1:0] new_slot;

	cld_store u_store (
		.clk      (clk),
		.val_acc  (val_acc),
		.next_acc (next_acc),
		.prev_acc (prev_acc),
		.val_rd   (val_rd),
		.next_rd  (next_rd),
		.prev_rd  (prev_rd)
	);

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// Capacity above the slot count acts as the slot count
	assign cap_eff = (cap_q > DEPTH_CNT) ? DEPTH_CNT : cap_q;

	// Slot an insert takes: free list first, then the never-used region
	assign new_slot = (free_q != NULL_SLOT) ? free_q : mark_q;

	always_comb begin
		case (cmd.func)
			FUNC_INSERT:  acc_status = (count_q >= cap_eff) ? STAT_FULL : STAT_OK;
			FUNC_DEQUEUE: acc_status = (count_q == '0) ? STAT_EMPTY : STAT_OK;
			FUNC_POP:     acc_status = (count_q == '0) ? STAT_EMPTY : STAT_OK;
			default:      acc_status = STAT_OK;
		endcase
	end

	always_comb begin
		state_nxt  = state_q;
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		free_nxt   = free_q;
		mark_nxt   = mark_q;
		count_nxt  = count_q;
		front_nxt  = front_q;
		back_nxt   = back_q;
		done_nxt   = 1'b0;
		result_nxt = result_q;

		val_acc  = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
		next_acc = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
		prev_acc = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

		case (state_q)
			S_IDLE: begin
				// Fetch the link the next step needs: the free list's successor
				// for an insert, the head's successor for a pop, the tail's
				// predecessor for a dequeue.
				next_acc.raddr = (cmd.func == FUNC_INSERT) ? free_q[ADDR_W-1:0]
					: head_q[ADDR_W-1:0];
				prev_acc.raddr = tail_q[ADDR_W-1:0];
				if (accept && acc_status == STAT_OK) begin
					case (cmd.func)
						FUNC_INSERT: begin
							// New head has no predecessor
							prev_acc.we    = 1'b1;
							prev_acc.waddr = new_slot[ADDR_W-1:0];
							prev_acc.wdata = NULL_SLOT;
						end
						FUNC_DEQUEUE: begin
							// Push the old tail onto the free list
							next_acc.we    = 1'b1;
							next_acc.waddr = tail_q[ADDR_W-1:0];
							next_acc.wdata = free_q;
						end
						default: begin
						end
					endcase
				end
				if (accept) begin
					state_nxt = S_LINK;
				end
			end

			S_LINK: begin
				if (status_q != STAT_OK) begin
					state_nxt = S_IDLE;
					done_nxt  = 1'b1;
				end else begin
					case (func_q)
						FUNC_INSERT: begin
							val_acc.we     = 1'b1;
							val_acc.waddr  = new_slot[ADDR_W-1:0];
							val_acc.wdata  = value_q;
							next_acc.we    = 1'b1;
							next_acc.waddr = new_slot[ADDR_W-1:0];
							next_acc.wdata = head_q;
							prev_acc.we    = (head_q != NULL_SLOT);
							prev_acc.waddr = head_q[ADDR_W-1:0];
							prev_acc.wdata = new_slot;
							if (free_q != NULL_SLOT) begin
								free_nxt = next_rd;
							end else begin
								mark_nxt = mark_q + 1'b1;
							end
							if (head_q == NULL_SLOT) begin
								tail_nxt = new_slot;
								back_nxt = value_q;
							end
							head_nxt  = new_slot;
							front_nxt = value_q;
							count_nxt = count_q + 1'b1;
							state_nxt = S_IDLE;
							done_nxt  = 1'b1;
						end
						FUNC_POP: begin
							// Release the old head, detach the new one
							next_acc.we    = 1'b1;
							next_acc.waddr = head_q[ADDR_W-1:0];
							next_acc.wdata = free_q;
							prev_acc.we    = (next_rd != NULL_SLOT);
							prev_acc.waddr = next_rd[ADDR_W-1:0];
							prev_acc.wdata = NULL_SLOT;
							val_acc.raddr  = next_rd[ADDR_W-1:0];
							free_nxt       = head_q;
							head_nxt       = next_rd;
							if (next_rd == NULL_SLOT) begin
								tail_nxt = NULL_SLOT;
							end
							count_nxt = count_q - 1'b1;
							state_nxt = S_FIN;
						end
						FUNC_DEQUEUE: begin
							// Old tail's link already points at the free list; make it the free head and cut the new tail's link
							next_acc.we    = (prev_rd != NULL_SLOT);
							next_acc.waddr = prev_rd[ADDR_W-1:0];
							next_acc.wdata = NULL_SLOT;
							val_acc.raddr  = prev_rd[ADDR_W-1:0];
							free_nxt       = tail_q;
							tail_nxt       = prev_rd;
							if (prev_rd == NULL_SLOT) begin
								head_nxt = NULL_SLOT;
							end
							count_nxt = count_q - 1'b1;
							state_nxt = S_FIN;
						end
						default: begin
							state_nxt = S_IDLE;
							done_nxt  = 1'b1;
						end
					endcase
				end
			end

			S_FIN: begin
				// Value of the new end is in from the value memory
				if (func_q == FUNC_POP) begin
					front_nxt = (head_q == NULL_SLOT) ? '0 : val_rd;
					back_nxt  = (head_q == NULL_SLOT) ? '0 : back_q;
				end else begin
					back_nxt  = (tail_q == NULL_SLOT) ? '0 : val_rd;
					front_nxt = (tail_q == NULL_SLOT) ? '0 : front_q;
				end
				state_nxt = S_IDLE;
				done_nxt  = 1'b1;
			end

			default: begin
				state_nxt = S_IDLE;
			end
		endcase

		if (done_nxt) begin
			result_nxt.removed_value = '0;
			if (status_q == STAT_OK && state_q == S_FIN) begin
				result_nxt.removed_value = (func_q == FUNC_POP) ? front_q : back_q;
			end
			result_nxt.status      = status_q;
			result_nxt.count       = count_nxt;
			result_nxt.front_value = front_nxt;
			result_nxt.back_value  = back_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NULL_SLOT;
			tail_q  <= NULL_SLOT;
			free_q  <= NULL_SLOT;
			mark_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
			front_q <= '0;
			back_q  <= '0;
		end else begin
			state_q <= state_nxt;
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			free_q  <= free_nxt;
			mark_q  <= mark_nxt;
			count_q <= count_nxt;
			done_q  <= done_nxt;
			front_q <= front_nxt;
			back_q  <= back_nxt;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	// Hold the command for its remaining steps; payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= cmd.func;
			value_q  <= cmd.value;
			status_q <= acc_status;
		end
		result_q <= result_nxt;
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while a request is still in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NULL_SLOT) == (tail_q == NULL_SLOT))
		else $error("head and tail pointers disagree on emptiness");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NULL_SLOT) == (count_q == '0))
		else $error("entry count disagrees with head pointer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond slot count");
`endif

endmodule

`default_nettype wire
